/* sv/pmsc_pkg.sv */
// ----------------------------------------------------------------------------
// pmsc_pkg
// Shared types and constants for the PID motor speed controller.
// ----------------------------------------------------------------------------
package pmsc_pkg;

	localparam int GAIN_BITS = 32;
	localparam int SUM_BITS  = 32;
	localparam int FRAC_BITS = 16;
	localparam int CTRL_BITS = 64;
	localparam int INT_BITS  = CTRL_BITS - FRAC_BITS;

	typedef logic signed [GAIN_BITS-1:0] gain_t;
	typedef logic signed [SUM_BITS-1:0]  sum_t;
	typedef logic signed [CTRL_BITS-1:0] ctrl_t;
	typedef logic [1:0]                  cfg_index_t;

	typedef struct packed {
		gain_t kp;
		gain_t ki_dt;
		gain_t kd_over_dt;
	} gains_t;

	localparam cfg_index_t CFG_KP_GAIN         = 2'd0;
	localparam cfg_index_t CFG_KI_DT_GAIN      = 2'd1;
	localparam cfg_index_t CFG_KD_OVER_DT_GAIN = 2'd2;

	localparam sum_t  SUM_MAX     = 32'sh7FFF_FFFF;
	localparam sum_t  SUM_MIN     = 32'sh8000_0000;
	localparam ctrl_t ITERM_LIMIT = 64'sd39321600;
	localparam ctrl_t PROD_LIMIT  = 64'sh2000_0000_0000_0000;

endpackage

/* sv/pmsc_sample_if.sv */
// ----------------------------------------------------------------------------
// pmsc_sample_if
// Input channel: target and measured encoder readings with valid/ready.
// ----------------------------------------------------------------------------
interface pmsc_sample_if #(
	parameter int MEASURE_BITS = 16
);
	logic                           valid;
	logic                           ready;
	logic signed [MEASURE_BITS-1:0] target_value;
	logic signed [MEASURE_BITS-1:0] measured_value;

	modport source (output valid, output target_value, output measured_value, input ready);
	modport sink (input valid, input target_value, input measured_value, output ready);
endinterface

/* sv/pmsc_result_if.sv */
// ----------------------------------------------------------------------------
// pmsc_result_if
// Output channel: motor direction and PWM duty with valid/ready.
// ----------------------------------------------------------------------------
interface pmsc_result_if #(
	parameter int DUTY_BITS = 10
);
	logic                 valid;
	logic                 ready;
	logic                 direction;
	logic [DUTY_BITS-1:0] duty;

	modport source (output valid, output direction, output duty, input ready);
	modport sink (input valid, input direction, input duty, output ready);
endinterface

/* sv/pmsc_gain_regs.sv */
// ----------------------------------------------------------------------------
// pmsc_gain_regs
// Gain register file written through the configuration port.
// ----------------------------------------------------------------------------
module pmsc_gain_regs (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  pmsc_pkg::cfg_index_t  cfg_index,
	input  pmsc_pkg::gain_t       cfg_wdata,
	output pmsc_pkg::gains_t      gains
);
	import pmsc_pkg::*;

	gains_t gains_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q <= '0;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_KP_GAIN:         gains_q.kp <= cfg_wdata;
				CFG_KI_DT_GAIN:      gains_q.ki_dt <= cfg_wdata;
				CFG_KD_OVER_DT_GAIN: gains_q.kd_over_dt <= cfg_wdata;
				default: begin
					// drop writes to unknown registers
				end
			endcase
		end
	end

	assign gains = gains_q;

endmodule

/* sv/pmsc_error_stage.sv */
// ----------------------------------------------------------------------------
// pmsc_error_stage
// Error, saturating error sum and error delta; holds the controller state.
// ----------------------------------------------------------------------------
module pmsc_error_stage #(
	parameter int MEASURE_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [MEASURE_BITS-1:0] target_value,
	input  logic signed [MEASURE_BITS-1:0] measured_value,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [MEASURE_BITS:0]   error,
	output logic signed [MEASURE_BITS+1:0] delta,
	output pmsc_pkg::sum_t                 error_sum
);
	import pmsc_pkg::*;

	localparam int ERR_BITS  = MEASURE_BITS + 1;
	localparam int DIFF_BITS = MEASURE_BITS + 2;
	localparam int ACC_BITS  = ((ERR_BITS > SUM_BITS) ? ERR_BITS : SUM_BITS) + 1;
	localparam logic signed [ACC_BITS-1:0] ACC_MAX = ACC_BITS'(SUM_MAX);
	localparam logic signed [ACC_BITS-1:0] ACC_MIN = ACC_BITS'(SUM_MIN);

	logic                         valid_s1;
	logic signed [ERR_BITS-1:0]   error_s1;
	logic signed [DIFF_BITS-1:0]  delta_s1;
	sum_t                         sum_s1;
	logic signed [ERR_BITS-1:0]   prev_error_q;
	sum_t                         error_sum_q;

	logic signed [ERR_BITS-1:0]   err_c;
	logic signed [DIFF_BITS-1:0]  delta_c;
	logic signed [ACC_BITS-1:0]   acc_c;
	sum_t                         sum_c;
	logic                         accept;

	assign in_ready = !valid_s1 || out_ready;
	assign accept   = in_valid && in_ready;

	always_comb begin
		err_c   = ERR_BITS'(target_value) - ERR_BITS'(measured_value);
		delta_c = DIFF_BITS'(err_c) - DIFF_BITS'(prev_error_q);
		acc_c   = ACC_BITS'(error_sum_q) + ACC_BITS'(err_c);
		if (acc_c > ACC_MAX) begin
			sum_c = SUM_MAX;
		end else if (acc_c < ACC_MIN) begin
			sum_c = SUM_MIN;
		end else begin
			sum_c = SUM_BITS'(acc_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			prev_error_q <= '0;
			error_sum_q  <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (accept) begin
				prev_error_q <= err_c;
				error_sum_q  <= sum_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			error_s1 <= err_c;
			delta_s1 <= delta_c;
			sum_s1   <= sum_c;
		end
	end

	assign out_valid = valid_s1;
	assign error     = error_s1;
	assign delta     = delta_s1;
	assign error_sum = sum_s1;

endmodule

/* sv/pmsc_term_stage.sv */
// ----------------------------------------------------------------------------
// pmsc_term_stage
// Proportional, integral and derivative products with their limits.
// ----------------------------------------------------------------------------
module pmsc_term_stage #(
	parameter int MEASURE_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pmsc_pkg::gains_t               gains,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [MEASURE_BITS:0]   error,
	input  logic signed [MEASURE_BITS+1:0] delta,
	input  pmsc_pkg::sum_t                 error_sum,
	output logic                           out_valid,
	input  logic                           out_ready,
	output pmsc_pkg::ctrl_t                p_term,
	output pmsc_pkg::ctrl_t                i_term,
	output pmsc_pkg::ctrl_t                d_term
);
	import pmsc_pkg::*;

	localparam int ERR_BITS  = MEASURE_BITS + 1;
	localparam int DIFF_BITS = MEASURE_BITS + 2;
	localparam int P_BITS    = GAIN_BITS + ERR_BITS;
	localparam int D_BITS    = GAIN_BITS + DIFF_BITS;
	localparam int WIDE_BITS = (D_BITS > CTRL_BITS) ? D_BITS : CTRL_BITS;
	localparam logic signed [WIDE_BITS-1:0] LIM_POS = WIDE_BITS'(PROD_LIMIT);
	localparam logic signed [WIDE_BITS-1:0] LIM_NEG = -LIM_POS;

	logic                         valid_s2;
	ctrl_t                        p_term_s2;
	ctrl_t                        i_term_s2;
	ctrl_t                        d_term_s2;

	logic signed [P_BITS-1:0]     p_prod;
	logic signed [D_BITS-1:0]     d_prod;
	ctrl_t                        i_prod;
	logic signed [WIDE_BITS-1:0]  p_wide;
	logic signed [WIDE_BITS-1:0]  d_wide;
	ctrl_t                        p_c;
	ctrl_t                        d_c;
	ctrl_t                        i_c;

	assign in_ready = !valid_s2 || out_ready;

	assign p_prod = gains.kp * error;
	assign d_prod = gains.kd_over_dt * delta;
	assign i_prod = gains.ki_dt * error_sum;
	assign p_wide = WIDE_BITS'(p_prod);
	assign d_wide = WIDE_BITS'(d_prod);

	always_comb begin
		if (p_wide > LIM_POS) begin
			p_c = PROD_LIMIT;
		end else if (p_wide < LIM_NEG) begin
			p_c = -PROD_LIMIT;
		end else begin
			p_c = CTRL_BITS'(p_wide);
		end
		if (d_wide > LIM_POS) begin
			d_c = PROD_LIMIT;
		end else if (d_wide < LIM_NEG) begin
			d_c = -PROD_LIMIT;
		end else begin
			d_c = CTRL_BITS'(d_wide);
		end
		if (i_prod > ITERM_LIMIT) begin
			i_c = ITERM_LIMIT;
		end else if (i_prod < -ITERM_LIMIT) begin
			i_c = -ITERM_LIMIT;
		end else begin
			i_c = i_prod;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			p_term_s2 <= p_c;
			i_term_s2 <= i_c;
			d_term_s2 <= d_c;
		end
	end

	assign out_valid = valid_s2;
	assign p_term    = p_term_s2;
	assign i_term    = i_term_s2;
	assign d_term    = d_term_s2;

endmodule

/* sv/pmsc_output_stage.sv */
// ----------------------------------------------------------------------------
// pmsc_output_stage
// Control sum, direction and saturated duty into the result register.
// ----------------------------------------------------------------------------
module pmsc_output_stage #(
	parameter int DUTY_BITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  pmsc_pkg::ctrl_t       p_term,
	input  pmsc_pkg::ctrl_t       i_term,
	input  pmsc_pkg::ctrl_t       d_term,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  direction,
	output logic [DUTY_BITS-1:0]  duty
);
	import pmsc_pkg::*;

	logic                   valid_s3;
	logic                   direction_s3;
	logic [DUTY_BITS-1:0]   duty_s3;

	ctrl_t                  ctrl_c;
	logic [CTRL_BITS-1:0]   mag_c;
	logic [INT_BITS-1:0]    int_c;
	logic [DUTY_BITS-1:0]   duty_c;

	assign in_ready = !valid_s3 || out_ready;

	always_comb begin
		ctrl_c = p_term + i_term + d_term;
		mag_c  = ctrl_c[CTRL_BITS-1] ? (~ctrl_c + 1'b1) : ctrl_c;
		int_c  = mag_c[CTRL_BITS-1:FRAC_BITS];
		if (|int_c[INT_BITS-1:DUTY_BITS]) begin
			duty_c = '1;
		end else begin
			duty_c = int_c[DUTY_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			direction_s3 <= ctrl_c[CTRL_BITS-1];
			duty_s3      <= duty_c;
		end
	end

	assign out_valid = valid_s3;
	assign direction = direction_s3;
	assign duty      = duty_s3;

endmodule

/* sv/pid_motor_speed_controller.sv */
// ----------------------------------------------------------------------------
// pid_motor_speed_controller
// An accepted sample passes the error, term and output stage registers to its result beat.
// Throughput: one sample per cycle; each of the three stage registers
// advances when the stage after it is empty or moving.
// Reset clears the pipeline valids, the error history, the error sum and
// all gains; it takes effect at once, with no clearing pass.
// ----------------------------------------------------------------------------
module pid_motor_speed_controller #(
	parameter int MEASURE_BITS = 16,
	parameter int DUTY_BITS    = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  pmsc_pkg::cfg_index_t cfg_index,
	input  pmsc_pkg::gain_t      cfg_wdata,
	pmsc_sample_if.sink          sample,
	pmsc_result_if.source        result
);
	import pmsc_pkg::*;

	gains_t                         gains;
	logic                           s1_valid;
	logic                           s1_ready;
	logic signed [MEASURE_BITS:0]   s1_error;
	logic signed [MEASURE_BITS+1:0] s1_delta;
	sum_t                           s1_sum;
	logic                           s2_valid;
	logic                           s2_ready;
	ctrl_t                          s2_p_term;
	ctrl_t                          s2_i_term;
	ctrl_t                          s2_d_term;

	pmsc_gain_regs u_gain_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.gains     (gains)
	);

	pmsc_error_stage #(
		.MEASURE_BITS (MEASURE_BITS)
	) u_error_stage (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (sample.valid),
		.in_ready       (sample.ready),
		.target_value   (sample.target_value),
		.measured_value (sample.measured_value),
		.out_valid      (s1_valid),
		.out_ready      (s1_ready),
		.error          (s1_error),
		.delta          (s1_delta),
		.error_sum      (s1_sum)
	);

	pmsc_term_stage #(
		.MEASURE_BITS (MEASURE_BITS)
	) u_term_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.gains     (gains),
		.in_valid  (s1_valid),
		.in_ready  (s1_ready),
		.error     (s1_error),
		.delta     (s1_delta),
		.error_sum (s1_sum),
		.out_valid (s2_valid),
		.out_ready (s2_ready),
		.p_term    (s2_p_term),
		.i_term    (s2_i_term),
		.d_term    (s2_d_term)
	);

	pmsc_output_stage #(
		.DUTY_BITS (DUTY_BITS)
	) u_output_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s2_valid),
		.in_ready  (s2_ready),
		.p_term    (s2_p_term),
		.i_term    (s2_i_term),
		.d_term    (s2_d_term),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.direction (result.direction),
		.duty      (result.duty)
	);

`ifndef NO_ASSERTIONS
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) |=> s1_valid)
		else $error("accepted sample did not reach stage 1");

	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && s2_valid && result.valid && !result.ready) |-> !sample.ready)
		else $error("input ready while pipeline is full and stalled");

	a_s2_moves_out: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_valid && (!result.valid || result.ready)) |=> result.valid)
		else $error("stage 2 item lost on the way to the result register");

	a_stall_keeps_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_valid && result.valid && !result.ready) |=> s2_valid)
		else $error("stage 2 item dropped during a stall");
`endif

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the PID motor speed controller. A scoreboard keeps
// its own copy of the gains, the error history and the saturating error sum,
// predicts direction and duty for every accepted sample beat and checks each
// result beat in order. Stimulus runs directed corner samples, then random
// phases under varied gain settings with random idling on both channels and
// one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pmsc_pkg::*;

	localparam int          MEASURE_BITS = 16;
	localparam int          DUTY_BITS    = 10;
	localparam longint      DUTY_MAX     = (64'sd1 <<< DUTY_BITS) - 1;
	localparam cfg_index_t  CFG_UNUSED   = 2'd3;
	localparam int unsigned CYCLE_LIMIT  = 1_000_000;
	localparam int          PHASE_SAMPLES = 220;

	typedef logic signed [MEASURE_BITS-1:0] reading_t;

	typedef struct {
		logic                 direction;
		logic [DUTY_BITS-1:0] duty;
	} drive_cmd_t;

	class duty_predictor;
		gains_t                       gains;
		logic signed [MEASURE_BITS:0] last_err;
		sum_t                         err_sum;
		drive_cmd_t                   expected_cmds[$];
		int unsigned                  failures;

		function new();
			gains    = '0;
			last_err = '0;
			err_sum  = '0;
			failures = 0;
		endfunction

		function void set_gain(cfg_index_t idx, gain_t value);
			case (idx)
				CFG_KP_GAIN:         gains.kp = value;
				CFG_KI_DT_GAIN:      gains.ki_dt = value;
				CFG_KD_OVER_DT_GAIN: gains.kd_over_dt = value;
				default: ;
			endcase
		endfunction

		function longint clamp_product(longint p);
			if (p > PROD_LIMIT)
				return PROD_LIMIT;
			if (p < -PROD_LIMIT)
				return -PROD_LIMIT;
			return p;
		endfunction

		function void note_sample(reading_t target, reading_t measured);
			longint     err, acc, iterm, pterm, dterm, ctrl, magnitude;
			drive_cmd_t cmd;
			err = longint'(target) - longint'(measured);
			acc = longint'(err_sum) + err;
			if (acc > longint'(SUM_MAX))
				acc = SUM_MAX;
			if (acc < longint'(SUM_MIN))
				acc = SUM_MIN;
			err_sum = sum_t'(acc);
			iterm = longint'(gains.ki_dt) * longint'(err_sum);
			if (iterm > ITERM_LIMIT)
				iterm = ITERM_LIMIT;
			if (iterm < -ITERM_LIMIT)
				iterm = -ITERM_LIMIT;
			pterm = clamp_product(longint'(gains.kp) * err);
			dterm = clamp_product(longint'(gains.kd_over_dt) * (err - longint'(last_err)));
			ctrl = pterm + dterm + iterm;
			magnitude = (ctrl < 0 ? -ctrl : ctrl) >>> FRAC_BITS;
			if (magnitude > DUTY_MAX)
				magnitude = DUTY_MAX;
			cmd.direction = (ctrl < 0);
			cmd.duty = magnitude[DUTY_BITS-1:0];
			expected_cmds.push_back(cmd);
			last_err = err[MEASURE_BITS:0];
		endfunction

		function void check_result(logic direction, logic [DUTY_BITS-1:0] duty);
			drive_cmd_t cmd;
			if (expected_cmds.size() == 0) begin
				$display("%0t: unexpected result beat, direction %0b duty %0d",
					$time, direction, duty);
				failures++;
				return;
			end
			cmd = expected_cmds.pop_front();
			if (direction !== cmd.direction) begin
				$display("%0t: direction expected %0b actual %0b",
					$time, cmd.direction, direction);
				failures++;
			end
			if (duty !== cmd.duty) begin
				$display("%0t: duty expected %0d actual %0d", $time, cmd.duty, duty);
				failures++;
			end
		endfunction

		function int pending();
			return expected_cmds.size();
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_wen;
	cfg_index_t cfg_index;
	gain_t      cfg_wdata;
	bit         calm;

	duty_predictor pred;

	pmsc_sample_if #(.MEASURE_BITS(MEASURE_BITS)) sample_ch ();
	pmsc_result_if #(.DUTY_BITS(DUTY_BITS))       result_ch ();

	pid_motor_speed_controller #(
		.MEASURE_BITS(MEASURE_BITS),
		.DUTY_BITS(DUTY_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.sample(sample_ch),
		.result(result_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic send_sample(reading_t target, reading_t measured);
		int gap;
		gap = 0;
		while (!calm && $urandom_range(99) < 19)
			gap++;
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.target_value <= target;
		sample_ch.measured_value <= measured;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		pred.note_sample(target, measured);
	endtask

	function automatic reading_t pick_reading();
		case ($urandom_range(4))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'sh0000;
			3: return -16'sd1;
			default: return 16'sd1;
		endcase
	endfunction

	task automatic send_random_sample();
		int       mode, near;
		reading_t target, measured;
		mode = $urandom_range(9);
		measured = reading_t'($urandom);
		target = reading_t'($urandom);
		if (mode < 5) begin
			near = int'(measured) + int'($urandom_range(1200)) - 600;
			if (near > 32767)
				near = 32767;
			if (near < -32768)
				near = -32768;
			target = reading_t'(near);
		end else if (mode >= 8) begin
			target = pick_reading();
			measured = pick_reading();
		end
		send_sample(target, measured);
	endtask

	function automatic gain_t pick_gain();
		case ($urandom_range(9))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return '0;
			3, 4, 5: return gain_t'(int'($urandom_range(131072)) - 65536);
			6, 7: return gain_t'(int'($urandom_range(2048)) - 1024);
			default: return gain_t'($urandom);
		endcase
	endfunction

	task automatic put_reg(cfg_index_t idx, gain_t value);
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		pred.set_gain(idx, value);
	endtask

	task automatic load_gains(gain_t kp, gain_t ki_dt, gain_t kd_over_dt, bit poke_unused);
		cfg_wen <= 1'b1;
		put_reg(CFG_KP_GAIN, kp);
		put_reg(CFG_KI_DT_GAIN, ki_dt);
		put_reg(CFG_KD_OVER_DT_GAIN, kd_over_dt);
		if (poke_unused)
			put_reg(CFG_UNUSED, gain_t'($urandom));
		cfg_wen <= 1'b0;
	endtask

	task automatic drain();
		sample_ch.valid <= 1'b0;
		while (pred.pending() != 0)
			@(posedge clk);
	endtask

	// receiver: random stalls plus one long hold-off to back up the pipeline
	initial begin : receiver
		int unsigned seen, hold_left;
		bit          held;
		seen = 0;
		hold_left = 0;
		held = 1'b0;
		result_ch.ready = 1'b0;
		do
			@(posedge clk);
		while (arst_n !== 1'b1);
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				pred.check_result(result_ch.direction, result_ch.duty);
				seen++;
			end
			if (!held && seen == 400) begin
				held = 1'b1;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= calm || ($urandom_range(99) >= 19);
			end
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[pid_motor_speed_controller] ERROR");
		$finish;
	end

	initial begin : stimulus
		pred = new();
		calm = 1'b0;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = CFG_KP_GAIN;
		cfg_wdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.target_value = '0;
		sample_ch.measured_value = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unity proportional gain, stray write to the unused index
		load_gains(32'sh0001_0000, '0, '0, 1'b1);
		send_sample(16'sd0, 16'sd0);
		send_sample(16'sd1, 16'sd0);
		send_sample(16'sd0, 16'sd1);
		send_sample(16'sd1023, 16'sd0);
		send_sample(16'sd1024, 16'sd0);
		send_sample(16'sh7FFF, 16'sh8000);
		send_sample(16'sh8000, 16'sh7FFF);
		send_sample(16'sh8000, 16'sh8000);
		drain();

		// control value just either side of zero: duty zero, direction set only below zero
		load_gains(-32'sd1, '0, '0, 1'b0);
		send_sample(16'sd1, 16'sd0);
		send_sample(16'sd0, 16'sd1);
		drain();

		load_gains('0, '0, 32'sh0001_0000, 1'b0);
		send_sample(16'sd100, 16'sd0);
		send_sample(16'sd100, 16'sd0);
		send_sample(-16'sd200, 16'sd0);
		drain();

		// integral clamp on both sides
		load_gains('0, 32'sh7FFF_FFFF, '0, 1'b0);
		send_sample(16'sd1, 16'sd0);
		send_sample(16'sd1, 16'sd0);
		send_sample(16'sd0, 16'sd2);
		send_sample(16'sd0, 16'sd5);
		drain();

		load_gains(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
		send_sample(16'sh7FFF, 16'sh8000);
		send_sample(16'sh8000, 16'sh7FFF);
		drain();

		load_gains(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
		send_sample(16'sh7FFF, 16'sh8000);
		send_sample(16'sh8000, 16'sh7FFF);
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			load_gains(pick_gain(), pick_gain(), pick_gain(), phase == 2);
			calm = (phase == 3);
			repeat (PHASE_SAMPLES) send_random_sample();
			drain();
			calm = 1'b0;
		end

		repeat (8) @(posedge clk);
		if (pred.failures == 0 && pred.pending() == 0) begin
			$display("[pid_motor_speed_controller] OK");
		end else begin
			$display("[pid_motor_speed_controller] ERROR");
		end
		$finish;
	end
endmodule

/* pid_motor_speed_controller.f */
sv/pmsc_pkg.sv
sv/pmsc_sample_if.sv
sv/pmsc_result_if.sv
sv/pmsc_gain_regs.sv
sv/pmsc_error_stage.sv
sv/pmsc_term_stage.sv
sv/pmsc_output_stage.sv
sv/pid_motor_speed_controller.sv
bench/tb.sv
